[src/lzbd_pkg.sv]
// lzbd_pkg: types and fixed format constants of the lz back-reference stream decompressor
// no dependencies; used by lz_backref_stream_decompressor_core

package lzbd_pkg;

    // stream format
    localparam logic [31:0] MAGIC_WORD     = 32'h5961_7A30;
    localparam logic [3:0]  MAGIC_LAST_IDX = 4'd3;
    localparam logic [3:0]  SIZE_END_IDX   = 4'd8;
    localparam logic [3:0]  HDR_LAST_IDX   = 4'd15;
    localparam int          BYTE_W         = 8;
    localparam int          FLAG_MSB       = 7;
    localparam int          DIST_W         = 12;
    localparam int          LEN_W          = 9;
    localparam logic [8:0]  SHORT_LEN_BIAS = 9'd2;
    localparam logic [8:0]  LONG_LEN_BIAS  = 9'h12;

    // result layout
    localparam int OUT_W   = 64;
    localparam int CNT_W   = 4;
    localparam int LANE_MAX = OUT_W / BYTE_W;
    localparam int LIDX_W  = $clog2(LANE_MAX);

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_BAD_MAGIC = 2'd1,
        STAT_BAD_DIST  = 2'd2
    } status_t;

endpackage

[src/lz_backref_stream_decompressor_core.sv]
// lz_backref_stream_decompressor_core: yaz0-style stream decoder with a 4 KiB history ram
// depends on lzbd_pkg
//
//  port group  dir  payload                                         transfer when
//  s_axis_*    in   tdata[7:0] in_byte, tuser[0] start_of_stream     tvalid & tready
//  m_axis_*    out  tdata[63:0] bytes, [67:64] count, tlast, tuser   tvalid & tready
//
// header, flag and reference prefix bytes are accepted in ST_IN; a literal goes on to ST_FIN;
// a back-reference of clipped length goes on to ST_COPY, copying one byte per cycle through
// the single-port-read history ram (registered read, write-to-read forwarding for distance 1),
// then to ST_FIN; error and empty-stream events go to ST_EMIT; a full output register stalls the copy
// rst_n clears all control state asynchronously; the history ram is not cleared,
// start_of_stream restarts the parser but keeps the window write position

module lz_backref_stream_decompressor_core #(
    parameter int WINDOW_DEPTH = 4096,
    parameter int OUT_LANES    = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
    input  logic [0:0]  s_axis_tuser,   // [0] start_of_stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata,   // [63:0] out_bytes, [67:64] byte_count, [71:68] zero
    output logic        m_axis_tlast,   // last_of_run
    output logic [2:0]  m_axis_tuser    // [0] stream_done, [2:1] status
);

    localparam int AW = $clog2(WINDOW_DEPTH);
    localparam logic [AW:0] DEPTH_VAL = (AW+1)'(WINDOW_DEPTH);
    localparam logic [lzbd_pkg::CNT_W-1:0] LANES_VAL = lzbd_pkg::CNT_W'(OUT_LANES);

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_FLAG,
        PH_ITEM,
        PH_REF2,
        PH_REF3,
        PH_DONE,
        PH_ERROR
    } phase_t;

    typedef enum logic [1:0] {
        ST_IN,
        ST_COPY,
        ST_FIN,
        ST_EMIT
    } ctrl_t;

    // history ram
    logic [7:0]    win_mem [WINDOW_DEPTH];
    logic [7:0]    mem_q_reg;
    logic          mem_we;
    logic          mem_re;
    logic [AW-1:0] mem_ra;
    logic [7:0]    mem_wd;

    // control and parser state
    ctrl_t                  state_reg, state_next;
    phase_t                 phase_reg, phase_next;
    logic [3:0]             hidx_reg, hidx_next;
    logic [7:0]             flags_reg, flags_next;
    logic [3:0]             fleft_reg, fleft_next;
    logic [7:0]             pend_reg, pend_next;
    logic [AW-1:0]          pend_off_reg, pend_off_next;
    logic [31:0]            size_reg, size_next;    // declared size, then bytes still to produce
    logic [AW:0]            prod_reg, prod_next;    // produced bytes, saturating at the depth
    logic [AW-1:0]          wp_reg, wp_next;
    lzbd_pkg::status_t      err_reg, err_next;

    // copy engine
    logic [AW-1:0]               rd_reg, rd_next;
    logic [lzbd_pkg::LEN_W-1:0]  issue_reg, issue_next;
    logic                        rv_reg, rv_next;
    logic                        fwd_reg, fwd_next;
    logic [7:0]                  fwd_data_reg, fwd_data_next;

    // lane collector
    logic [lzbd_pkg::OUT_W-1:0]  lane_data_reg, lane_data_next;
    logic [lzbd_pkg::CNT_W-1:0]  lane_n_reg, lane_n_next;

    // output register
    logic                        out_valid_reg, out_valid_next;
    logic [lzbd_pkg::OUT_W-1:0]  out_data_reg, out_data_next;
    logic [lzbd_pkg::CNT_W-1:0]  out_cnt_reg, out_cnt_next;
    logic                        out_last_reg, out_last_next;
    logic                        out_done_reg, out_done_next;
    lzbd_pkg::status_t           out_stat_reg, out_stat_next;

    // working values
    logic                        out_free;
    logic                        lanes_full;
    logic                        stall;
    logic [7:0]                  rd_byte;
    logic [7:0]                  in_b;
    logic                        start;
    phase_t                      ph_eff;
    logic [3:0]                  hidx_eff;
    logic [31:0]                 size_eff;
    logic [31:0]                 size_sh;
    logic [AW:0]                 ref_dist;
    logic [lzbd_pkg::LEN_W-1:0]  len_raw;
    logic [lzbd_pkg::LEN_W-1:0]  len_eff;
    logic [AW-1:0]               cp_off;
    logic                        cp_start;
    logic [3:0]                  fleft_dec;

    function automatic logic [lzbd_pkg::OUT_W-1:0] lane_insert(
        input logic [lzbd_pkg::OUT_W-1:0]  data,
        input logic [lzbd_pkg::LIDX_W-1:0] idx,
        input logic [7:0]                  b
    );
        logic [lzbd_pkg::OUT_W-1:0] res;
        res = data;
        for (int i = 0; i < lzbd_pkg::LANE_MAX; i++) begin
            if (idx == lzbd_pkg::LIDX_W'(i)) begin
                res[i*lzbd_pkg::BYTE_W +: lzbd_pkg::BYTE_W] = b;
            end
        end
        return res;
    endfunction

    assign s_axis_tready = (state_reg == ST_IN);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'b0000, out_cnt_reg, out_data_reg};
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tuser  = {out_stat_reg, out_done_reg};

    assign out_free   = !out_valid_reg || m_axis_tready;
    assign lanes_full = (lane_n_reg == LANES_VAL);
    assign stall      = rv_reg && lanes_full && !out_free;
    assign rd_byte    = fwd_reg ? fwd_data_reg : mem_q_reg;
    assign in_b       = s_axis_tdata;
    assign start      = s_axis_tuser[0];
    assign ph_eff     = start ? PH_HEADER : phase_reg;
    assign hidx_eff   = start ? 4'd0 : hidx_reg;
    assign size_eff   = start ? 32'd0 : size_reg;
    assign size_sh    = {size_eff[23:0], in_b};
    assign fleft_dec  = (fleft_reg != 4'd0) ? fleft_reg - 4'd1 : 4'd0;

    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        hidx_next      = hidx_reg;
        flags_next     = flags_reg;
        fleft_next     = fleft_reg;
        pend_next      = pend_reg;
        pend_off_next  = pend_off_reg;
        size_next      = size_reg;
        prod_next      = prod_reg;
        wp_next        = wp_reg;
        err_next       = err_reg;
        rd_next        = rd_reg;
        issue_next     = issue_reg;
        rv_next        = rv_reg;
        fwd_next       = fwd_reg;
        fwd_data_next  = fwd_data_reg;
        lane_data_next = lane_data_reg;
        lane_n_next    = lane_n_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_data_next  = out_data_reg;
        out_cnt_next   = out_cnt_reg;
        out_last_next  = out_last_reg;
        out_done_next  = out_done_reg;
        out_stat_next  = out_stat_reg;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        mem_ra         = rd_reg;
        mem_wd         = rd_byte;
        ref_dist       = {1'b0, pend_reg[3:0], in_b} + (AW+1)'(1);
        len_raw        = '0;
        cp_off         = pend_off_reg;
        cp_start       = 1'b0;
        len_eff        = '0;

        case (state_reg)
            ST_IN:
            begin
                if (s_axis_tvalid)
                begin
                    if (start)
                    begin
                        hidx_next  = 4'd0;
                        flags_next = 8'd0;
                        fleft_next = 4'd0;
                        pend_next  = 8'd0;
                        size_next  = 32'd0;
                        prod_next  = '0;
                        err_next   = lzbd_pkg::STAT_OK;
                        phase_next = PH_HEADER;
                    end
                    case (ph_eff)
                        PH_HEADER:
                        begin
                            if (hidx_eff < lzbd_pkg::SIZE_END_IDX)
                            begin
                                size_next = size_sh;
                            end
                            if (hidx_eff == lzbd_pkg::MAGIC_LAST_IDX &&
                                size_sh != lzbd_pkg::MAGIC_WORD)
                            begin
                                err_next   = lzbd_pkg::STAT_BAD_MAGIC;
                                phase_next = PH_ERROR;
                                state_next = ST_EMIT;
                            end
                            else
                            begin
                                if (hidx_eff == lzbd_pkg::MAGIC_LAST_IDX)
                                begin
                                    size_next = 32'd0;
                                end
                                if (hidx_eff == lzbd_pkg::HDR_LAST_IDX)
                                begin
                                    hidx_next = 4'd0;
                                    if (size_eff == 32'd0)
                                    begin
                                        phase_next = PH_DONE;
                                        state_next = ST_EMIT;
                                    end
                                    else
                                    begin
                                        phase_next = PH_FLAG;
                                    end
                                end
                                else
                                begin
                                    hidx_next = hidx_eff + 4'd1;
                                end
                            end
                        end
                        PH_FLAG:
                        begin
                            flags_next = in_b;
                            fleft_next = 4'd8;
                            phase_next = PH_ITEM;
                        end
                        PH_ITEM:
                        begin
                            if (flags_reg[lzbd_pkg::FLAG_MSB])
                            begin
                                // literal: lanes are empty between items
                                mem_we         = 1'b1;
                                mem_wd         = in_b;
                                wp_next        = wp_reg + AW'(1);
                                prod_next      = (prod_reg != DEPTH_VAL) ? prod_reg + (AW+1)'(1)
                                                                         : prod_reg;
                                size_next      = size_reg - 32'd1;
                                lane_data_next = lane_insert('0, '0, in_b);
                                lane_n_next    = lzbd_pkg::CNT_W'(1);
                                state_next     = ST_FIN;
                            end
                            else
                            begin
                                pend_next  = in_b;
                                phase_next = PH_REF2;
                            end
                        end
                        PH_REF2:
                        begin
                            if (ref_dist > prod_reg)
                            begin
                                err_next   = lzbd_pkg::STAT_BAD_DIST;
                                phase_next = PH_ERROR;
                                state_next = ST_EMIT;
                            end
                            else if (pend_reg[7:4] != 4'd0)
                            begin
                                len_raw  = lzbd_pkg::LEN_W'(pend_reg[7:4]) + lzbd_pkg::SHORT_LEN_BIAS;
                                cp_off   = ref_dist[AW-1:0];
                                cp_start = 1'b1;
                            end
                            else
                            begin
                                pend_off_next = ref_dist[AW-1:0];
                                phase_next    = PH_REF3;
                            end
                        end
                        PH_REF3:
                        begin
                            len_raw  = lzbd_pkg::LEN_W'(in_b) + lzbd_pkg::LONG_LEN_BIAS;
                            cp_start = 1'b1;
                        end
                        default:
                        begin
                            // done or error: byte dropped
                        end
                    endcase

                    if (cp_start)
                    begin
                        // clip the copy at the declared size
                        len_eff    = (size_reg < 32'(len_raw)) ? size_reg[lzbd_pkg::LEN_W-1:0]
                                                                : len_raw;
                        issue_next = len_eff;
                        rd_next    = wp_reg - cp_off;
                        rv_next    = 1'b0;
                        fwd_next   = 1'b0;
                        state_next = ST_COPY;
                    end
                end
            end

            ST_COPY:
            begin
                if (!stall)
                begin
                    if (rv_reg)
                    begin
                        mem_we    = 1'b1;
                        mem_wd    = rd_byte;
                        wp_next   = wp_reg + AW'(1);
                        prod_next = (prod_reg != DEPTH_VAL) ? prod_reg + (AW+1)'(1) : prod_reg;
                        size_next = size_reg - 32'd1;
                        if (lanes_full)
                        begin
                            out_valid_next = 1'b1;
                            out_data_next  = lane_data_reg;
                            out_cnt_next   = lane_n_reg;
                            out_last_next  = 1'b0;
                            out_done_next  = 1'b0;
                            out_stat_next  = lzbd_pkg::STAT_OK;
                            lane_data_next = lane_insert('0, '0, rd_byte);
                            lane_n_next    = lzbd_pkg::CNT_W'(1);
                        end
                        else
                        begin
                            lane_data_next = lane_insert(lane_data_reg,
                                                         lane_n_reg[lzbd_pkg::LIDX_W-1:0],
                                                         rd_byte);
                            lane_n_next    = lane_n_reg + lzbd_pkg::CNT_W'(1);
                        end
                    end
                    if (issue_reg != '0)
                    begin
                        mem_re        = 1'b1;
                        mem_ra        = rd_reg;
                        rd_next       = rd_reg + AW'(1);
                        issue_next    = issue_reg - lzbd_pkg::LEN_W'(1);
                        rv_next       = 1'b1;
                        // read of the entry written in this same cycle
                        fwd_next      = rv_reg && (rd_reg == wp_reg);
                        fwd_data_next = rd_byte;
                    end
                    else
                    begin
                        rv_next    = 1'b0;
                        fwd_next   = 1'b0;
                        state_next = ST_FIN;
                    end
                end
            end

            ST_FIN:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = lane_data_reg;
                    out_cnt_next   = lane_n_reg;
                    out_last_next  = 1'b1;
                    out_done_next  = (size_reg == 32'd0);
                    out_stat_next  = lzbd_pkg::STAT_OK;
                    lane_data_next = '0;
                    lane_n_next    = '0;
                    flags_next     = {flags_reg[6:0], 1'b0};
                    fleft_next     = fleft_dec;
                    if (size_reg == 32'd0)
                    begin
                        phase_next = PH_DONE;
                    end
                    else if (fleft_dec == 4'd0)
                    begin
                        phase_next = PH_FLAG;
                    end
                    else
                    begin
                        phase_next = PH_ITEM;
                    end
                    state_next = ST_IN;
                end
            end

            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = '0;
                    out_cnt_next   = '0;
                    out_last_next  = 1'b1;
                    out_done_next  = (phase_reg == PH_DONE);
                    out_stat_next  = err_reg;
                    state_next     = ST_IN;
                end
            end

            default:
            begin
                state_next = ST_IN;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            win_mem[wp_reg] <= mem_wd;
        end
        if (mem_re)
        begin
            mem_q_reg <= win_mem[mem_ra];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IN;
            phase_reg     <= PH_HEADER;
            hidx_reg      <= 4'd0;
            flags_reg     <= 8'd0;
            fleft_reg     <= 4'd0;
            pend_reg      <= 8'd0;
            pend_off_reg  <= '0;
            size_reg      <= 32'd0;
            prod_reg      <= '0;
            wp_reg        <= '0;
            err_reg       <= lzbd_pkg::STAT_OK;
            rd_reg        <= '0;
            issue_reg     <= '0;
            rv_reg        <= 1'b0;
            fwd_reg       <= 1'b0;
            lane_n_reg    <= '0;
            lane_data_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            hidx_reg      <= hidx_next;
            flags_reg     <= flags_next;
            fleft_reg     <= fleft_next;
            pend_reg      <= pend_next;
            pend_off_reg  <= pend_off_next;
            size_reg      <= size_next;
            prod_reg      <= prod_next;
            wp_reg        <= wp_next;
            err_reg       <= err_next;
            rd_reg        <= rd_next;
            issue_reg     <= issue_next;
            rv_reg        <= rv_next;
            fwd_reg       <= fwd_next;
            lane_n_reg    <= lane_n_next;
            lane_data_reg <= lane_data_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fwd_data_reg <= fwd_data_next;
        out_data_reg <= out_data_next;
        out_cnt_reg  <= out_cnt_next;
        out_last_reg <= out_last_next;
        out_done_reg <= out_done_next;
        out_stat_reg <= out_stat_next;
    end

    // no new input while a copy is still reading or writing the window
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> (issue_reg == '0 && !rv_reg))
        else $error("input ready during a window copy");

    // forwarded data only ever stands in for a pending read
    a_fwd_pending: assert property (@(posedge clk) disable iff (!rst_n)
        fwd_reg |-> rv_reg)
        else $error("forward flag without a pending read");

    // a result that is not last carries a full group and no error
    a_mid_full: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_last_reg) |->
            (out_cnt_reg == LANES_VAL && out_stat_reg == lzbd_pkg::STAT_OK))
        else $error("partial group before the end of a run");

    // an empty result is always an event closing the run
    a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_cnt_reg == '0) |-> out_last_reg)
        else $error("empty result not marked last");

endmodule

[test/lz_backref_stream_decompressor_core_tb.sv]
`timescale 1ns / 100ps
// lz_backref_stream_decompressor_core_tb: self-checking bench for the yaz0-style stream decoder,
// with a behavioral decoder that predicts every output group and a stream builder for stimulus
// depends on lzbd_pkg and lz_backref_stream_decompressor_core

module lz_backref_stream_decompressor_core_tb;

    localparam int     HALF_PERIOD = 5;
    localparam int     WIN_DEPTH   = 4096;
    localparam int     DRAIN_WAIT  = 300;
    localparam longint WATCHDOG_NS = 10_000_000;
    localparam int     PRINT_CAP   = 40;

    typedef enum logic [2:0] {
        ST_HEADER,
        ST_FLAG,
        ST_ITEM,
        ST_REF_LO,
        ST_REF_LEN,
        ST_DONE,
        ST_HALT
    } parse_state_t;

    typedef struct packed {
        logic [63:0]       data;
        logic [3:0]        count;
        logic              is_last;
        logic              is_done;
        lzbd_pkg::status_t stat;
    } group_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;   // [7:0] in_byte
    logic [0:0]  s_axis_tuser;   // [0] start_of_stream
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [71:0] m_axis_tdata;   // [63:0] out_bytes, [67:64] byte_count, [71:68] zero
    logic        m_axis_tlast;   // last_of_run
    logic [2:0]  m_axis_tuser;   // [0] stream_done, [2:1] status

    lz_backref_stream_decompressor_core uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #HALF_PERIOD clk = ~clk;

    // decoder state mirrored from the block
    parse_state_t      st;
    logic [3:0]        hdr_pos;
    logic [7:0]        flag_reg;
    logic [3:0]        flag_cnt;
    logic [7:0]        ref_hi;
    logic [31:0]       size_goal;
    logic [31:0]       out_total;
    logic [7:0]        hist [WIN_DEPTH];
    logic [11:0]       hist_wr;
    logic [12:0]       far_dist;
    lzbd_pkg::status_t err_stat;
    logic [63:0]       grp_data;
    int                grp_fill;

    group_t       step_groups[$];
    group_t       expected_groups[$];
    group_t       want;
    logic [7:0]   stream_bytes[$];

    int src_idle_pct;
    int sink_idle_pct;
    int hold_len;
    int hold_seq = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int bytes_sent = 0;
    int groups_checked = 0;
    int mismatches = 0;

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want_v);
        if (mismatches < PRINT_CAP)
            $display("mismatch at %0t: %s got %h want %h", $realtime, what, got, want_v);
        mismatches++;
    endtask

    task automatic clear_parser();
        st        = ST_HEADER;
        hdr_pos   = 4'd0;
        flag_reg  = 8'd0;
        flag_cnt  = 4'd0;
        ref_hi    = 8'd0;
        size_goal = 32'd0;
        out_total = 32'd0;
        far_dist  = 13'd0;
        err_stat  = lzbd_pkg::STAT_OK;
    endtask

    task automatic push_group(input bit last, input bit done);
        group_t g;
        g.data    = grp_data;
        g.count   = grp_fill[3:0];
        g.is_last = last;
        g.is_done = done;
        g.stat    = err_stat;
        step_groups.push_back(g);
        grp_data = '0;
        grp_fill = 0;
    endtask

    task automatic put_out(input logic [7:0] b);
        hist[hist_wr] = b;
        hist_wr = hist_wr + 12'd1;
        out_total = out_total + 32'd1;
        grp_data[grp_fill*8 +: 8] = b;
        grp_fill++;
        if (grp_fill >= lzbd_pkg::LANE_MAX)
            push_group(1'b0, 1'b0);
    endtask

    task automatic finish_item();
        flag_reg = flag_reg << 1;
        if (flag_cnt > 4'd0)
            flag_cnt = flag_cnt - 4'd1;
        if (out_total == size_goal)
            st = ST_DONE;
        else
            st = (flag_cnt == 4'd0) ? ST_FLAG : ST_ITEM;
    endtask

    task automatic copy_back(input logic [12:0] ref_dist, input logic [8:0] len);
        int i;
        logic [11:0] rd;
        for (i = 0; i < len && out_total != size_goal; i++)
        begin
            rd = hist_wr - ref_dist[11:0];
            put_out(hist[rd]);
        end
        finish_item();
    endtask

    task automatic raise_err(input lzbd_pkg::status_t code);
        err_stat = code;
        st = ST_HALT;
        grp_data = '0;
        grp_fill = 0;
        push_group(1'b1, 1'b0);
    endtask

    // predicts the output groups of one accepted compressed byte
    task automatic decode_byte(input logic [7:0] b, input logic sos);
        bit quiet;
        logic [12:0] ref_dist;
        group_t g;
        quiet = 1'b0;
        grp_data = '0;
        grp_fill = 0;
        if (sos)
            clear_parser();
        case (st)
            ST_HEADER:
            begin
                if (hdr_pos < lzbd_pkg::SIZE_END_IDX)
                    size_goal = {size_goal[23:0], b};
                if (hdr_pos == lzbd_pkg::MAGIC_LAST_IDX && size_goal != lzbd_pkg::MAGIC_WORD)
                begin
                    raise_err(lzbd_pkg::STAT_BAD_MAGIC);
                    quiet = 1'b1;
                end
                else
                begin
                    if (hdr_pos == lzbd_pkg::MAGIC_LAST_IDX)
                        size_goal = 32'd0;
                    if (hdr_pos == lzbd_pkg::HDR_LAST_IDX)
                    begin
                        hdr_pos = 4'd0;
                        if (size_goal == 32'd0)
                        begin
                            st = ST_DONE;
                            push_group(1'b1, 1'b1);
                            quiet = 1'b1;
                        end
                        else
                            st = ST_FLAG;
                    end
                    else
                        hdr_pos = hdr_pos + 4'd1;
                end
            end
            ST_FLAG:
            begin
                flag_reg = b;
                flag_cnt = 4'd8;
                st = ST_ITEM;
            end
            ST_ITEM:
            begin
                if (flag_reg[lzbd_pkg::FLAG_MSB])
                begin
                    put_out(b);
                    finish_item();
                end
                else
                begin
                    ref_hi = b;
                    st = ST_REF_LO;
                end
            end
            ST_REF_LO:
            begin
                ref_dist = {1'b0, ref_hi[3:0], b} + 13'd1;
                if ({19'd0, ref_dist} > out_total)
                begin
                    raise_err(lzbd_pkg::STAT_BAD_DIST);
                    quiet = 1'b1;
                end
                else if (ref_hi[7:4] != 4'd0)
                    copy_back(ref_dist, {5'd0, ref_hi[7:4]} + lzbd_pkg::SHORT_LEN_BIAS);
                else
                begin
                    far_dist = ref_dist;
                    st = ST_REF_LEN;
                end
            end
            ST_REF_LEN:
                copy_back(far_dist, {1'b0, b} + lzbd_pkg::LONG_LEN_BIAS);
            default:
                quiet = 1'b1;
        endcase
        if (!quiet)
        begin
            if (grp_fill > 0)
                push_group(1'b1, st == ST_DONE);
            else if (step_groups.size() > 0)
            begin
                // a full group closed the run, so it carries the end flags
                g = step_groups.pop_back();
                g.is_last = 1'b1;
                if (st == ST_DONE)
                    g.is_done = 1'b1;
                step_groups.push_back(g);
            end
        end
        while (step_groups.size() > 0)
            expected_groups.push_back(step_groups.pop_front());
    endtask

    // one transfer on the input side; entered and left at a falling edge
    task automatic send_byte(input logic [7:0] b, input logic sos);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tuser  <= sos;
        do
            @(posedge clk);
        while (!s_axis_tready);
        decode_byte(b, sos);
        @(negedge clk);
    endtask

    task automatic send_stream(input bit mark_start);
        foreach (stream_bytes[k])
        begin
            send_byte(stream_bytes[k], mark_start && k == 0);
            bytes_sent++;
        end
    endtask

    task automatic push_header(input logic [31:0] size);
        stream_bytes.push_back(lzbd_pkg::MAGIC_WORD[31:24]);
        stream_bytes.push_back(lzbd_pkg::MAGIC_WORD[23:16]);
        stream_bytes.push_back(lzbd_pkg::MAGIC_WORD[15:8]);
        stream_bytes.push_back(lzbd_pkg::MAGIC_WORD[7:0]);
        stream_bytes.push_back(size[31:24]);
        stream_bytes.push_back(size[23:16]);
        stream_bytes.push_back(size[15:8]);
        stream_bytes.push_back(size[7:0]);
        repeat (8)
            stream_bytes.push_back(8'($urandom));
    endtask

    // well-formed stream of the given decoded size; distances stay within produced data
    // unless want_bad_dist places one reference past it
    task automatic build_stream(input int size, input int ref_pct, input int long_pct,
                                input bit want_bad_dist);
        int made;
        int slot;
        int ref_dist;
        int len;
        int far;
        bit bad_done;
        logic [7:0]  flag;
        logic [11:0] code;
        logic [3:0]  nib;
        logic [7:0]  body[$];
        stream_bytes = {};
        push_header(size);
        made = 0;
        bad_done = 1'b0;
        while (made < size)
        begin
            flag = 8'($urandom);
            body = {};
            for (slot = 7; slot >= 0 && made < size; slot--)
            begin
                if (made == 0 || $urandom_range(99) >= ref_pct)
                begin
                    flag[slot] = 1'b1;
                    body.push_back(8'($urandom));
                    made++;
                end
                else
                begin
                    flag[slot] = 1'b0;
                    far = made < WIN_DEPTH ? made : WIN_DEPTH;
                    case ($urandom_range(9))
                        0:       ref_dist = far;
                        1, 2, 3: ref_dist = $urandom_range(far, 1);
                        default: ref_dist = $urandom_range(far < 16 ? far : 16, 1);
                    endcase
                    if (want_bad_dist && !bad_done && made < WIN_DEPTH && $urandom_range(2) == 0)
                    begin
                        ref_dist = $urandom_range(WIN_DEPTH, made + 1);
                        bad_done = 1'b1;
                    end
                    code = 12'(ref_dist - 1);
                    if ($urandom_range(99) < long_pct)
                    begin
                        len = $urandom_range(273, 18);
                        body.push_back({4'h0, code[11:8]});
                        body.push_back(code[7:0]);
                        body.push_back(8'(len - 18));
                    end
                    else
                    begin
                        len = $urandom_range(17, 3);
                        nib = 4'(len - 2);
                        body.push_back({nib, code[11:8]});
                        body.push_back(code[7:0]);
                    end
                    made += len;
                end
            end
            stream_bytes.push_back(flag);
            foreach (body[k])
                stream_bytes.push_back(body[k]);
        end
    endtask

    // no start mark after reset, literal extremes, longest short and long copies with
    // overlap, a copy clipped at the declared size, then a byte after done
    task automatic test_headerless_stream();
        stream_bytes = {};
        push_header(32'd100);
        stream_bytes.push_back(8'hC0);
        stream_bytes.push_back(8'h00);
        stream_bytes.push_back(8'hFF);
        stream_bytes.push_back(8'hF0);
        stream_bytes.push_back(8'h01);
        stream_bytes.push_back(8'h00);
        stream_bytes.push_back(8'h00);
        stream_bytes.push_back(8'hFF);
        send_stream(1'b0);
        send_byte(8'h5A, 1'b0);
    endtask

    task automatic test_bad_magic();
        stream_bytes = {8'h59, 8'h61, 8'h7A, 8'h31};
        send_stream(1'b1);
        send_byte(8'hA5, 1'b0);
    endtask

    task automatic test_empty_stream();
        stream_bytes = {};
        push_header(32'd0);
        send_stream(1'b1);
        send_byte(8'h3C, 1'b0);
    endtask

    // maximum distance field while only one byte exists
    task automatic test_bad_distance();
        stream_bytes = {};
        push_header(32'd8);
        stream_bytes.push_back(8'h80);
        stream_bytes.push_back(8'hA5);
        stream_bytes.push_back(8'h1F);
        stream_bytes.push_back(8'hFF);
        send_stream(1'b1);
    endtask

    task automatic test_random_streams();
        int phase;
        int kind;
        int quota;
        int pos;
        for (phase = 0; phase < 3; phase++)
        begin
            src_idle_pct  = (phase == 0) ? 9 : (phase == 1) ? 85 : 0;
            sink_idle_pct = (phase == 0) ? 85 : (phase == 1) ? 9 : 0;
            quota = bytes_sent + 50;
            while (bytes_sent < quota)
            begin
                kind = $urandom_range(99);
                if (kind < 75)
                    build_stream($urandom_range(40, 1), 40, 15, 1'b0);
                else if (kind < 80)
                    build_stream($urandom_range(300, 100), 60, 40, 1'b0);
                else if (kind < 88)
                    build_stream($urandom_range(60, 4), 70, 20, 1'b1);
                else if (kind < 94)
                begin
                    build_stream($urandom_range(20, 1), 40, 15, 1'b0);
                    pos = $urandom_range(3);
                    stream_bytes[pos] = stream_bytes[pos] ^ (8'h01 << $urandom_range(7));
                end
                else
                begin
                    stream_bytes = {};
                    repeat ($urandom_range(6, 1))
                        stream_bytes.push_back(8'($urandom));
                end
                // cut a stream short so the next start mark lands mid-parse
                if (kind < 80 && $urandom_range(9) == 0)
                begin
                    pos = $urandom_range(stream_bytes.size() - 1, 1);
                    while (stream_bytes.size() > pos)
                        stream_bytes.delete(stream_bytes.size() - 1);
                end
                send_stream(kind < 94 ? 1'b1 : 1'($urandom_range(1)));
                if ($urandom_range(3) == 0)
                    send_byte(8'($urandom), 1'b0);
            end
        end
    endtask

    // long receiver stall over a large stream so the output side backs up into the input
    task automatic test_output_backpressure();
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        build_stream(4500, 85, 70, 1'b0);
        hold_len = 600;
        hold_seq++;
        send_stream(1'b1);
    endtask

    always @(negedge clk)
    begin
        if (hold_seen != hold_seq)
        begin
            hold_seen = hold_seq;
            hold_left = hold_len;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            groups_checked++;
            if (expected_groups.size() == 0)
                report_mismatch("transfer with nothing expected", m_axis_tdata[63:0], '0);
            else
            begin
                want = expected_groups.pop_front();
                if (m_axis_tdata[63:0] !== want.data)
                    report_mismatch("out_bytes", m_axis_tdata[63:0], want.data);
                if (m_axis_tdata[67:64] !== want.count)
                    report_mismatch("byte_count", 64'(m_axis_tdata[67:64]), 64'(want.count));
                if (m_axis_tlast !== want.is_last)
                    report_mismatch("last_of_run", 64'(m_axis_tlast), 64'(want.is_last));
                if (m_axis_tuser[0] !== want.is_done)
                    report_mismatch("stream_done", 64'(m_axis_tuser[0]), 64'(want.is_done));
                if (m_axis_tuser[2:1] !== want.stat)
                    report_mismatch("status", 64'(m_axis_tuser[2:1]), 64'(want.stat));
            end
        end
    end

    initial
    begin
        #(WATCHDOG_NS);
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 8'd0;
        s_axis_tuser  = 1'b0;
        src_idle_pct  = 9;
        sink_idle_pct = 85;
        hold_len      = 0;
        clear_parser();
        hist_wr = 12'd0;
        repeat (12)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_headerless_stream();
        test_bad_magic();
        test_empty_stream();
        test_bad_distance();
        test_random_streams();
        test_output_backpressure();
        s_axis_tvalid <= 1'b0;

        while (expected_groups.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT)
            @(posedge clk);

        $display("summary: %0d compressed bytes, %0d output transfers checked, %0d mismatches",
                 bytes_sent, groups_checked, mismatches);
        $display("summary: headerless start, bad magic, empty and clipped streams, bad distance, "
                 , "random streams under three idle mixes, long output stall");
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

[files.f]
src/lzbd_pkg.sv
src/lz_backref_stream_decompressor_core.sv
test/lz_backref_stream_decompressor_core_tb.sv
